// ===== design/jcsm_pkg.sv =====
// shared types and constants of the joystick centre split map
`default_nettype none

package jcsm_pkg;

	localparam int OUT_MAX_DEF  = 1000;
	localparam int ADC_BITS_DEF = 12;

	localparam int AXIS_W    = 11;
	localparam int CFG_IDX_W = 2;

	localparam int CAL_MIN_RST    = 0;
	localparam int CAL_CENTER_RST = 2048;
	localparam int CAL_MAX_RST    = 4095;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_MIN    = 2'd0,
		CFG_CENTER = 2'd1,
		CFG_MAX    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic lower;
		logic neg;
		logic err;
	} ctl_t;

endpackage

`default_nettype wire

// ===== design/jcsm_front.sv =====
// half select, magnitudes and scaling multiply (stages one and two)
`default_nettype none

module jcsm_front #(
	parameter int ADC_BITS = 12,
	parameter int OUT_MAX  = 1000
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          en_s1,
	input  wire                                          en_s2,
	input  wire                                          in_valid,
	input  wire  [ADC_BITS-1:0]                          adc_sample,
	input  wire  [ADC_BITS-1:0]                          cal_min,
	input  wire  [ADC_BITS-1:0]                          cal_center,
	input  wire  [ADC_BITS-1:0]                          cal_max,
	output logic                                         valid_s1,
	output logic                                         valid_s2,
	output logic [ADC_BITS+$clog2(OUT_MAX+1)-1:0]        prod_s2,
	output logic [ADC_BITS-1:0]                          dmag_s2,
	output jcsm_pkg::ctl_t                               ctl_s2
);
	import jcsm_pkg::*;

	localparam int OUT_W = $clog2(OUT_MAX + 1);
	localparam int NUM_W = ADC_BITS + OUT_W;
	localparam logic [NUM_W-1:0] SCALE = NUM_W'(OUT_MAX);

	logic                       upper;
	logic [ADC_BITS-1:0]        lo_sel;
	logic [ADC_BITS-1:0]        hi_sel;
	logic signed [ADC_BITS:0]   diff;
	logic signed [ADC_BITS:0]   den;
	logic [ADC_BITS:0]          diff_neg;
	logic [ADC_BITS:0]          den_neg;

	logic [ADC_BITS-1:0]        xmag_s1;
	logic [ADC_BITS-1:0]        dmag_s1;
	ctl_t                       ctl_s1;

	always_comb begin
		upper    = adc_sample >= cal_center;
		lo_sel   = upper ? cal_center : cal_min;
		hi_sel   = upper ? cal_max : cal_center;
		diff     = signed'({1'b0, adc_sample}) - signed'({1'b0, lo_sel});
		den      = signed'({1'b0, hi_sel}) - signed'({1'b0, lo_sel});
		diff_neg = (ADC_BITS+1)'(0) - diff;
		den_neg  = (ADC_BITS+1)'(0) - den;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			xmag_s1      <= diff[ADC_BITS] ? diff_neg[ADC_BITS-1:0] : diff[ADC_BITS-1:0];
			dmag_s1      <= den[ADC_BITS] ? den_neg[ADC_BITS-1:0] : den[ADC_BITS-1:0];
			ctl_s1.lower <= !upper;
			ctl_s1.neg   <= diff[ADC_BITS] ^ den[ADC_BITS];
			ctl_s1.err   <= den == '0;
		end
		if (en_s2 && valid_s1) begin
			prod_s2 <= NUM_W'(xmag_s1) * SCALE;
			dmag_s2 <= dmag_s1;
			ctl_s2  <= ctl_s1;
		end
	end

endmodule

`default_nettype wire

// ===== design/jcsm_div_stage.sv =====
// one restoring divider stage, one quotient bit per stage
`default_nettype none

module jcsm_div_stage #(
	parameter int ADC_BITS = 12,
	parameter int OUT_MAX  = 1000
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          en,
	input  wire                                          in_valid,
	input  wire  [ADC_BITS-1:0]                          rem_in,
	input  wire  [ADC_BITS+$clog2(OUT_MAX+1)-1:0]        work_in,
	input  wire  [ADC_BITS-1:0]                          dmag_in,
	input  wire  jcsm_pkg::ctl_t                         ctl_in,
	output logic                                         valid_sn,
	output logic [ADC_BITS-1:0]                          rem_sn,
	output logic [ADC_BITS+$clog2(OUT_MAX+1)-1:0]        work_sn,
	output logic [ADC_BITS-1:0]                          dmag_sn,
	output jcsm_pkg::ctl_t                               ctl_sn
);
	import jcsm_pkg::*;

	localparam int NUM_W = ADC_BITS + $clog2(OUT_MAX + 1);

	logic [ADC_BITS:0]   trial;
	logic [ADC_BITS:0]   sub;
	logic                ge;

	// remainder stays below the divisor, so the trial fits one extra bit
	always_comb begin
		trial = {rem_in, work_in[NUM_W-1]};
		sub   = trial - {1'b0, dmag_in};
		ge    = trial >= {1'b0, dmag_in};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			rem_sn  <= ge ? sub[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
			work_sn <= {work_in[NUM_W-2:0], ge};
			dmag_sn <= dmag_in;
			ctl_sn  <= ctl_in;
		end
	end

endmodule

`default_nettype wire

// ===== design/jcsm_back.sv =====
// sign restore, half offset, saturation and output register
`default_nettype none

module jcsm_back #(
	parameter int ADC_BITS = 12,
	parameter int OUT_MAX  = 1000
) (
	input  wire                                          clk,
	input  wire                                          arst_n,
	input  wire                                          en,
	input  wire                                          in_valid,
	input  wire  [ADC_BITS+$clog2(OUT_MAX+1)-1:0]        quot_in,
	input  wire  jcsm_pkg::ctl_t                         ctl_in,
	output logic                                         valid_so,
	output logic [jcsm_pkg::AXIS_W-1:0]                  axis_value_so,
	output logic                                         span_error_so
);
	import jcsm_pkg::*;

	localparam int NUM_W = ADC_BITS + $clog2(OUT_MAX + 1);
	localparam int WV    = NUM_W + 2;
	localparam logic signed [WV-1:0] LIM = WV'(OUT_MAX);

	logic signed [WV-1:0] q_ext;
	logic signed [WV-1:0] q_sgn;
	logic signed [WV-1:0] base;
	logic signed [WV-1:0] v;
	logic signed [WV-1:0] sat;

	always_comb begin
		q_ext = signed'({2'b00, quot_in});
		q_sgn = ctl_in.neg ? -q_ext : q_ext;
		base  = ctl_in.lower ? -LIM : '0;
		v     = q_sgn + base;
		if (ctl_in.err) begin
			sat = '0;
		end else if (v > LIM) begin
			sat = LIM;
		end else if (v < -LIM) begin
			sat = -LIM;
		end else begin
			sat = v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else if (en) begin
			valid_so <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			axis_value_so <= sat[AXIS_W-1:0];
			span_error_so <= ctl_in.err;
		end
	end

endmodule

`default_nettype wire

// ===== design/joystick_center_split_map_unit.sv =====
// top level of the joystick centre split map
//
// Maps one raw ADC sample of a joystick axis per item onto a signed stick
// position: samples at or above cal_center scale from centre..max onto
// 0..OUT_MAX, samples below scale from min..centre onto -OUT_MAX..0; each
// half's quotient truncates toward zero before the lower half's offset and
// saturation to plus or minus OUT_MAX. A zero half span gives 0, span_error set.
// Channels: sample (valid/ready, adc_sample), result (valid/ready,
// axis_value, span_error) and a cfg write port (index, data) that is always
// ready; write it only while no item is in flight.
// Two front stages come first, then one restoring divider stage per quotient
// bit, then the saturation and output register. Throughput is one item per
// cycle while the output is not stalled.
// When the receiver stalls, each stage holds its item and empty stages
// still fill, so samples keep being taken until the pipeline is full.
// Reset clears all valid bits and loads min 0, centre 2048, max 4095
// (masked to ADC_BITS).
`default_nettype none

module joystick_center_split_map_unit #(
	parameter int OUT_MAX  = jcsm_pkg::OUT_MAX_DEF,
	parameter int ADC_BITS = jcsm_pkg::ADC_BITS_DEF
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 sample_valid,
	output logic                                sample_ready,
	input  wire  [ADC_BITS-1:0]                 adc_sample,
	output logic                                result_valid,
	input  wire                                 result_ready,
	output logic [jcsm_pkg::AXIS_W-1:0]         axis_value,
	output logic                                span_error,
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [jcsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [ADC_BITS-1:0]                 cfg_data
);
	import jcsm_pkg::*;

	localparam int NUM_W = ADC_BITS + $clog2(OUT_MAX + 1);
	localparam int NSTG  = NUM_W + 3;
	localparam logic [ADC_BITS-1:0] MIN_RST    = ADC_BITS'(CAL_MIN_RST);
	localparam logic [ADC_BITS-1:0] CENTER_RST = ADC_BITS'(CAL_CENTER_RST);
	localparam logic [ADC_BITS-1:0] MAX_RST    = ADC_BITS'(CAL_MAX_RST);

	logic [ADC_BITS-1:0] cal_min_q;
	logic [ADC_BITS-1:0] cal_center_q;
	logic [ADC_BITS-1:0] cal_max_q;

	logic [NSTG-1:0]     en;
	wire  [NSTG-1:0]     vld;

	wire  [ADC_BITS-1:0] rem_a  [0:NUM_W];
	wire  [NUM_W-1:0]    work_a [0:NUM_W];
	wire  [ADC_BITS-1:0] dmag_a [0:NUM_W];
	wire  ctl_t          ctl_a  [0:NUM_W];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q    <= MIN_RST;
			cal_center_q <= CENTER_RST;
			cal_max_q    <= MAX_RST;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_MIN: begin
					cal_min_q <= cfg_data;
				end
				CFG_CENTER: begin
					cal_center_q <= cfg_data;
				end
				CFG_MAX: begin
					cal_max_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// a stage moves when it is empty or the stage after it moves
	always_comb begin
		en[NSTG-1] = !vld[NSTG-1] || result_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld[k] || en[k+1];
		end
	end

	assign sample_ready = en[0];
	assign result_valid = vld[NSTG-1];
	assign rem_a[0]     = '0;

	jcsm_front #(
		.ADC_BITS (ADC_BITS),
		.OUT_MAX  (OUT_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en_s1      (en[0]),
		.en_s2      (en[1]),
		.in_valid   (sample_valid),
		.adc_sample (adc_sample),
		.cal_min    (cal_min_q),
		.cal_center (cal_center_q),
		.cal_max    (cal_max_q),
		.valid_s1   (vld[0]),
		.valid_s2   (vld[1]),
		.prod_s2    (work_a[0]),
		.dmag_s2    (dmag_a[0]),
		.ctl_s2     (ctl_a[0])
	);

	for (genvar g = 0; g < NUM_W; g++) begin : g_div
		jcsm_div_stage #(
			.ADC_BITS (ADC_BITS),
			.OUT_MAX  (OUT_MAX)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en[g+2]),
			.in_valid (vld[g+1]),
			.rem_in   (rem_a[g]),
			.work_in  (work_a[g]),
			.dmag_in  (dmag_a[g]),
			.ctl_in   (ctl_a[g]),
			.valid_sn (vld[g+2]),
			.rem_sn   (rem_a[g+1]),
			.work_sn  (work_a[g+1]),
			.dmag_sn  (dmag_a[g+1]),
			.ctl_sn   (ctl_a[g+1])
		);
	end

	jcsm_back #(
		.ADC_BITS (ADC_BITS),
		.OUT_MAX  (OUT_MAX)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en[NSTG-1]),
		.in_valid      (vld[NSTG-2]),
		.quot_in       (work_a[NUM_W]),
		.ctl_in        (ctl_a[NUM_W]),
		.valid_so      (vld[NSTG-1]),
		.axis_value_so (axis_value),
		.span_error_so (span_error)
	);

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |=> vld[0])
		else $error("accepted item not held in first stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("stalled result dropped");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && span_error |-> axis_value == '0)
		else $error("span error with non-zero axis value");

endmodule

`default_nettype wire

// ===== bench/jcsm_checker.sv =====
// checker for the joystick centre split map: predicts each sample's axis value and compares
module jcsm_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 sample_valid,
	input  wire                                 sample_ready,
	input  wire  [jcsm_pkg::ADC_BITS_DEF-1:0]   adc_sample,
	input  wire                                 result_valid,
	input  wire                                 result_ready,
	input  wire  [jcsm_pkg::AXIS_W-1:0]         axis_value,
	input  wire                                 span_error,
	input  wire                                 cfg_valid,
	input  wire                                 cfg_ready,
	input  wire  [jcsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [jcsm_pkg::ADC_BITS_DEF-1:0]   cfg_data,
	output int                                  failures,
	output int                                  outstanding
);
	import jcsm_pkg::*;

	localparam int ABITS = ADC_BITS_DEF;
	localparam int FULL  = OUT_MAX_DEF;

	typedef struct packed {
		logic [AXIS_W-1:0] axis;
		logic              err;
	} stick_t;

	logic [ABITS-1:0] cal_lo;
	logic [ABITS-1:0] cal_mid;
	logic [ABITS-1:0] cal_hi;
	stick_t           stick_q[$];

	function automatic stick_t stick_of(input logic [ABITS-1:0] s);
		longint x, lo, c, hi, den, v;
		stick_t r;
		x = s;
		lo = cal_lo;
		c = cal_mid;
		hi = cal_hi;
		r.err = 1'b0;
		if (x >= c) begin
			den = hi - c;
			if (den == 0) begin
				r.err = 1'b1;
				v = 0;
			end else begin
				v = ((x - c) * FULL) / den;
			end
		end else begin
			den = c - lo;
			if (den == 0) begin
				r.err = 1'b1;
				v = 0;
			end else begin
				v = ((x - lo) * FULL) / den - FULL;
			end
		end
		if (v > FULL) v = FULL;
		if (v < -FULL) v = -FULL;
		r.axis = v[AXIS_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("checker: %s", msg);
		failures++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		stick_t want;
		if (!arst_n) begin
			cal_lo <= ABITS'(CAL_MIN_RST);
			cal_mid <= ABITS'(CAL_CENTER_RST);
			cal_hi <= ABITS'(CAL_MAX_RST);
			stick_q.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_MIN: cal_lo <= cfg_data;
					CFG_CENTER: cal_mid <= cfg_data;
					CFG_MAX: cal_hi <= cfg_data;
					default: ;
				endcase
			end
			if (result_valid && result_ready) begin
				if (stick_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item axis %0d err %0b",
						$signed(axis_value), span_error));
				end else begin
					want = stick_q.pop_front();
					if (axis_value !== want.axis)
						report_mismatch($sformatf("axis_value %0d, want %0d",
							$signed(axis_value), $signed(want.axis)));
					if (span_error !== want.err)
						report_mismatch($sformatf("span_error %0b, want %0b",
							span_error, want.err));
				end
			end
			if (sample_valid && sample_ready)
				stick_q.push_back(stick_of(adc_sample));
			outstanding <= stick_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
// testbench top: drives samples and calibration writes into the joystick centre split map
module tb;
	import jcsm_pkg::*;

	localparam int ABITS = ADC_BITS_DEF;
	localparam int TOP = (1 << ABITS) - 1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_ready;
	logic [ABITS-1:0]     adc_sample = '0;
	logic                 result_valid;
	logic                 result_ready = 1'b0;
	logic [AXIS_W-1:0]    axis_value;
	logic                 span_error;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN;
	logic [ABITS-1:0]     cfg_data = '0;
	int                   failures;
	int                   outstanding;
	int                   idle_pct = 0;

	joystick_center_split_map_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc_sample   (adc_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.axis_value   (axis_value),
		.span_error   (span_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	jcsm_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.adc_sample   (adc_sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.axis_value   (axis_value),
		.span_error   (span_error),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.outstanding  (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#800000;
		$display("tb: failure");
		$finish;
	end

	// receiver stalls in bursts
	initial begin
		int n;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 99) < idle_pct) begin
				n = $urandom_range(1, 10);
				result_ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			result_ready <= 1'b1;
			@(posedge clk);
		end
	end

	task automatic send_sample(input int s);
		int n;
		if ($urandom_range(0, 99) < idle_pct) begin
			n = $urandom_range(1, 10);
			sample_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample <= s[ABITS-1:0];
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
	endtask

	// hold off until every expected item has come back
	task automatic drain();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_cal(input logic [CFG_IDX_W-1:0] idx, input logic [ABITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic set_cal(input int lo, input int mid, input int hi, input bit junk);
		write_cal(CFG_MIN, lo[ABITS-1:0]);
		write_cal(CFG_CENTER, mid[ABITS-1:0]);
		if (junk)
			write_cal(CFG_UNUSED, ABITS'($urandom_range(0, TOP)));
		write_cal(CFG_MAX, hi[ABITS-1:0]);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int lo, mid, hi, sent, n, r, base, s;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration
		send_sample(0);
		send_sample(TOP);
		send_sample(2048);
		send_sample(2047);
		send_sample(1);
		drain();
		write_cal(CFG_UNUSED, '0);
		cfg_valid <= 1'b0;
		send_sample(0);
		// upper half with no span
		drain();
		set_cal(0, TOP, TOP, 1'b0);
		send_sample(TOP);
		send_sample(0);
		send_sample(3000);
		drain();
		set_cal(0, 0, 0, 1'b0);
		send_sample(0);
		// lower half with no span
		drain();
		set_cal(2000, 2000, 3000, 1'b0);
		send_sample(1000);
		send_sample(0);
		send_sample(2500);
		// inverted calibration
		drain();
		set_cal(3000, 2000, 1000, 1'b0);
		send_sample(0);
		send_sample(1500);
		send_sample(2000);
		send_sample(2500);
		send_sample(TOP);
		// samples beyond the calibrated ends
		drain();
		set_cal(1000, 1500, 2000, 1'b0);
		send_sample(0);
		send_sample(999);
		send_sample(1000);
		send_sample(2000);
		send_sample(TOP);
		send_sample(1499);

		sent = 0;
		while (sent < 550) begin
			drain();
			case ($urandom_range(0, 6))
				0: begin
					lo = $urandom_range(0, TOP);
					mid = $urandom_range(0, TOP);
					hi = $urandom_range(0, TOP);
				end
				1: begin
					lo = $urandom_range(0, 1) ? TOP : 0;
					mid = $urandom_range(0, 1) ? TOP : 0;
					hi = $urandom_range(0, 1) ? TOP : 0;
				end
				3: begin
					mid = $urandom_range(0, TOP);
					lo = $urandom_range(0, 1) ? mid : $urandom_range(0, TOP);
					hi = (lo == mid) ? $urandom_range(0, TOP) : mid;
				end
				4: begin
					mid = $urandom_range(1, TOP - 1);
					lo = $urandom_range(mid + 1, TOP);
					hi = $urandom_range(0, mid - 1);
				end
				default: begin
					mid = $urandom_range(1, TOP - 1);
					lo = $urandom_range(0, mid - 1);
					hi = $urandom_range(mid + 1, TOP);
				end
			endcase
			set_cal(lo, mid, hi, $urandom_range(0, 3) == 0);
			if (sent >= 490) begin
				idle_pct = 0;
				n = 60;
			end else begin
				case ($urandom_range(0, 3))
					0: idle_pct = 0;
					1: idle_pct = 10;
					2: idle_pct = 30;
					default: idle_pct = 60;
				endcase
				n = $urandom_range(20, 60);
			end
			repeat (n) begin
				r = $urandom_range(0, 9);
				if (r < 6) begin
					s = $urandom_range(0, TOP);
				end else if (r < 9) begin
					case ($urandom_range(0, 2))
						0: base = lo;
						1: base = mid;
						default: base = hi;
					endcase
					s = base + $urandom_range(0, 6) - 3;
					if (s < 0) s = 0;
					if (s > TOP) s = TOP;
				end else begin
					s = $urandom_range(0, 1) ? TOP : 0;
				end
				send_sample(s);
				sent++;
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (failures == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== joystick_center_split_map_unit.f =====
design/jcsm_pkg.sv
design/jcsm_front.sv
design/jcsm_div_stage.sv
design/jcsm_back.sv
design/joystick_center_split_map_unit.sv
bench/jcsm_checker.sv
bench/tb.sv
